FILE: rtl/bcm_pkg.sv
// bcm_pkg: shared types and codes for the capacity matcher
`default_nettype none
package bcm_pkg;
   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_OFFER = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXPAND,
      ST_RDM,
      ST_RDA,
      ST_UNWIND
   } state_type;

   localparam int CAP_W = 11;
   localparam int OUT_W = 11;
endpackage
`default_nettype wire

FILE: rtl/bcm_first_pick.sv
// bcm_first_pick: lowest set bit finder for the right node scan
`default_nettype none
module bcm_first_pick #(
   parameter int N  = 16,
   parameter int IW = 4
) (
   input  wire logic [N-1:0]  cand,
   output logic               found,
   output logic [IW-1:0]      index
);
   always_comb begin
      found = 1'b0;
      index = '0;
      for (int j = N - 1; j >= 0; j--) begin
         if (cand[j]) begin
            found = 1'b1;
            index = IW'(j);
         end
      end
   end
endmodule
`default_nettype wire

FILE: rtl/bipartite_capacity_matcher.sv
// bipartite_capacity_matcher: capacity-limited matcher by augmenting path search
// clear, load, none and skipped offers strobe their result in the cycle after start; busy stays low
// an offer holds busy for its search: it scans right nodes, tries their slots, descends
// by a match then mask memory read and writes each path step back
// the result strobes in the cycle after the search ends
// synchronous reset clears counts, capacities, flags; memories are not cleared
// one result strobe per item on rsp_valid; the receiver cannot stall
`default_nettype none
module bipartite_capacity_matcher
   import bcm_pkg::*;
#(
   parameter int LEFT_NODES  = 1024,
   parameter int RIGHT_NODES = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic [1:0]    req_mode,
   input  wire logic [3:0]    req_right_index,
   input  wire logic [10:0]   req_capacity_value,
   input  wire logic [15:0]   req_accept_mask,
   output logic               rsp_valid,
   output logic               rsp_placed,
   output logic [10:0]        rsp_people_seen,
   output logic               rsp_all_placed
);
   localparam int R   = RIGHT_NODES;
   localparam int PW  = $clog2(LEFT_NODES + 1);
   localparam int LW  = (LEFT_NODES > 1) ? $clog2(LEFT_NODES) : 1;
   localparam int VW  = (R > 1) ? $clog2(R) : 1;
   localparam int CW  = $clog2(R + 1);
   localparam int SW  = VW;
   localparam int AW  = (R * LEFT_NODES > 1) ? $clog2(R * LEFT_NODES) : 1;
   localparam int XW  = (PW > CAP_W) ? PW : CAP_W;
   localparam logic [R-1:0] ALL_R = {R{1'b1}};

   // memories
   logic [R-1:0]  adj_mem [LEFT_NODES];
   logic [LW-1:0] match_mem [R * LEFT_NODES];

   logic          adj_we;
   logic [LW-1:0] adj_waddr, adj_raddr;
   logic [R-1:0]  adj_wdata, adj_rd_ff;
   logic          match_we;
   logic [AW-1:0] match_waddr, match_raddr;
   logic [LW-1:0] match_wdata, match_rd_ff;

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_waddr] <= adj_wdata;
      end
      adj_rd_ff <= adj_mem[adj_raddr];
   end

   always_ff @(posedge clock) begin
      if (match_we) begin
         match_mem[match_waddr] <= match_wdata;
      end
      match_rd_ff <= match_mem[match_raddr];
   end

   // search stack
   logic [LW-1:0] stk_u    [R];
   logic [VW-1:0] stk_v    [R];
   logic [PW-1:0] stk_slot [R];
   logic [R-1:0]  stk_adj  [R];
   logic          push;

   state_type     state_ff, state_in;
   logic [PW-1:0] pc_ff, pc_in;
   logic          failed_ff, failed_in;
   logic [CAP_W-1:0] cap_ff [R];
   logic [PW-1:0] fill_ff [R];
   logic [R-1:0]  visited_ff, visited_in;
   logic [CW-1:0] top_ff, top_in;
   logic [LW-1:0] cur_u_ff, cur_u_in;
   logic [CW-1:0] cur_v_ff, cur_v_in;
   logic [PW-1:0] cur_slot_ff, cur_slot_in;
   logic [R-1:0]  cur_adj_ff, cur_adj_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_placed_ff, rsp_placed_in;
   logic [10:0]   rsp_people_ff, rsp_people_in;
   logic          rsp_all_ff, rsp_all_in;

   logic          cap_we;
   logic [VW-1:0] cap_idx;
   logic          clear;
   logic          fill_inc;
   logic [VW-1:0] fill_idx;

   logic [R-1:0]  geq_mask, cand;
   logic          pick_found;
   logic [VW-1:0] pick_idx;
   logic [CW-1:0] top_m1;
   logic [SW-1:0] pop_idx;
   logic [VW-1:0] ev;
   logic [PW-1:0] pick_fill;
   logic          room;

   always_comb begin
      for (int j = 0; j < R; j++) begin
         geq_mask[j] = (CW'(j) >= cur_v_ff);
      end
      cand = cur_adj_ff & ~visited_ff & geq_mask;
   end

   bcm_first_pick #(.N(R), .IW(VW)) u_pick (
      .cand  (cand),
      .found (pick_found),
      .index (pick_idx)
   );

   assign top_m1    = top_ff - CW'(1);
   assign pop_idx   = top_m1[SW-1:0];
   assign ev        = cur_v_ff[VW-1:0];
   assign pick_fill = fill_ff[pick_idx];
   assign room      = (XW'(pick_fill) < XW'(cap_ff[pick_idx])) &&
                      (pick_fill < PW'(LEFT_NODES));

   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      failed_in     = failed_ff;
      visited_in    = visited_ff;
      top_in        = top_ff;
      cur_u_in      = cur_u_ff;
      cur_v_in      = cur_v_ff;
      cur_slot_in   = cur_slot_ff;
      cur_adj_in    = cur_adj_ff;
      rsp_valid_in  = 1'b0;
      rsp_placed_in = rsp_placed_ff;
      rsp_people_in = rsp_people_ff;
      rsp_all_in    = rsp_all_ff;
      adj_we        = 1'b0;
      adj_waddr     = pc_ff[LW-1:0];
      adj_wdata     = req_accept_mask[R-1:0] & ALL_R;
      adj_raddr     = match_rd_ff;
      match_we      = 1'b0;
      match_waddr   = AW'(pick_idx) * AW'(LEFT_NODES) + AW'(pick_fill[LW-1:0]);
      match_wdata   = cur_u_ff;
      match_raddr   = AW'(ev) * AW'(LEFT_NODES) + AW'(cur_slot_ff[LW-1:0]);
      push          = 1'b0;
      cap_we        = 1'b0;
      cap_idx       = req_right_index[VW-1:0];
      clear         = 1'b0;
      fill_inc      = 1'b0;
      fill_idx      = pick_idx;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_valid_in  = 1'b1;
               rsp_placed_in = 1'b0;
               case (mode_type'(req_mode))
                  MODE_CLEAR: begin
                     clear     = 1'b1;
                     pc_in     = '0;
                     failed_in = 1'b0;
                     visited_in = '0;
                  end
                  MODE_LOAD: begin
                     cap_we = (32'(req_right_index) < R);
                  end
                  MODE_OFFER: begin
                     if (!failed_ff) begin
                        if (pc_ff == PW'(LEFT_NODES)) begin
                           failed_in = 1'b1;
                        end else begin
                           adj_we       = 1'b1;
                           pc_in        = pc_ff + PW'(1);
                           cur_u_in     = pc_ff[LW-1:0];
                           cur_v_in     = '0;
                           cur_adj_in   = req_accept_mask[R-1:0] & ALL_R;
                           visited_in   = '0;
                           top_in       = '0;
                           rsp_valid_in = 1'b0;
                           state_in     = ST_SCAN;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_people_in = OUT_W'(pc_in);
               rsp_all_in    = !failed_in;
            end
         end
         ST_SCAN: begin
            if (!pick_found) begin
               if (top_ff == '0) begin
                  failed_in     = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_placed_in = 1'b0;
                  rsp_people_in = OUT_W'(pc_ff);
                  rsp_all_in    = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  cur_u_in    = stk_u[pop_idx];
                  cur_v_in    = CW'(stk_v[pop_idx]);
                  cur_slot_in = stk_slot[pop_idx] + PW'(1);
                  cur_adj_in  = stk_adj[pop_idx];
                  top_in      = top_m1;
                  state_in    = ST_EXPAND;
               end
            end else begin
               visited_in           = visited_ff;
               visited_in[pick_idx] = 1'b1;
               cur_v_in             = CW'(pick_idx);
               if (room) begin
                  match_we = 1'b1;
                  fill_inc = 1'b1;
                  if (top_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_placed_in = 1'b1;
                     rsp_people_in = OUT_W'(pc_ff);
                     rsp_all_in    = !failed_ff;
                     state_in      = ST_IDLE;
                  end else begin
                     state_in = ST_UNWIND;
                  end
               end else begin
                  cur_slot_in = '0;
                  state_in    = ST_EXPAND;
               end
            end
         end
         ST_EXPAND: begin
            if ((cur_slot_ff < fill_ff[ev]) && (top_ff < CW'(R))) begin
               push     = 1'b1;
               top_in   = top_ff + CW'(1);
               state_in = ST_RDM;
            end else begin
               cur_v_in = cur_v_ff + CW'(1);
               state_in = ST_SCAN;
            end
         end
         ST_RDM: begin
            cur_u_in = match_rd_ff;
            state_in = ST_RDA;
         end
         ST_RDA: begin
            cur_adj_in = adj_rd_ff;
            cur_v_in   = '0;
            state_in   = ST_SCAN;
         end
         ST_UNWIND: begin
            match_we    = 1'b1;
            match_waddr = AW'(stk_v[pop_idx]) * AW'(LEFT_NODES) +
                          AW'(stk_slot[pop_idx][LW-1:0]);
            match_wdata = stk_u[pop_idx];
            top_in      = top_m1;
            if (top_ff == CW'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_placed_in = 1'b1;
               rsp_people_in = OUT_W'(pc_ff);
               rsp_all_in    = !failed_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         failed_ff    <= 1'b0;
         visited_ff   <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < R; j++) begin
            cap_ff[j]  <= '0;
            fill_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         failed_ff    <= failed_in;
         visited_ff   <= visited_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cap_we) begin
            cap_ff[cap_idx] <= req_capacity_value;
         end
         if (clear) begin
            for (int j = 0; j < R; j++) begin
               fill_ff[j] <= '0;
            end
         end else if (fill_inc) begin
            fill_ff[fill_idx] <= fill_ff[fill_idx] + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_u_ff      <= cur_u_in;
      cur_v_ff      <= cur_v_in;
      cur_slot_ff   <= cur_slot_in;
      cur_adj_ff    <= cur_adj_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_people_ff <= rsp_people_in;
      rsp_all_ff    <= rsp_all_in;
      if (push) begin
         stk_u[top_ff[SW-1:0]]    <= cur_u_ff;
         stk_v[top_ff[SW-1:0]]    <= ev;
         stk_slot[top_ff[SW-1:0]] <= cur_slot_ff;
         stk_adj[top_ff[SW-1:0]]  <= cur_adj_ff;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_placed      = rsp_placed_ff;
   assign rsp_people_seen = rsp_people_ff;
   assign rsp_all_placed  = rsp_all_ff;

`ifndef SYNTHESIS
   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe during search");
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= CW'(R))
      else $error("search stack overflow");
   a_start_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("item neither searched nor answered");
   a_placed_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_placed) |-> rsp_all_placed)
      else $error("placed item reported with failure flag");
`endif
endmodule
`default_nettype wire
